// ===== design/fp32as_pkg.sv =====
// Shared types and constants for the fp32 adder with step count.
// No dependencies.
package fp32as_pkg;
	localparam logic [31:0] NanWord = 32'h7F800001;
	localparam logic [8:0] ExpMax = 9'd254;

	// stage 1 -> stage 2: aligned operands
	typedef struct packed {
		logic        special;
		logic [31:0] special_word;
		logic        sign_a;
		logic        sign_b;
		logic [7:0]  exp_big;
		logic [7:0]  exp_diff;
		logic [63:0] sig_a;
		logic [63:0] sig_b;
		logic        aligned;
	} fp32as_align_t;

	// stage 2 -> stage 3: raw sum
	typedef struct packed {
		logic        special;
		logic [31:0] special_word;
		logic        sign;
		logic [7:0]  exp_big;
		logic [7:0]  exp_diff;
		logic [63:0] sum;
		logic        aligned;
	} fp32as_sum_t;

	// stage 3 -> stage 4: normalized
	typedef struct packed {
		logic        done;
		logic [31:0] word;
		logic        ovf;
		logic        unf;
		logic        sign;
		logic [8:0]  exp_n;
		logic [24:0] sig;
		logic        round_step;
		logic [2:0]  steps;
	} fp32as_norm_t;

	typedef struct packed {
		logic [31:0] word;
		logic        ovf;
		logic        unf;
		logic [2:0]  steps;
	} fp32as_res_t;
endpackage

// ===== design/fp32as_align.sv =====
// Stage 1 logic: special-case detection and sticky-bit alignment of operands.
// Depends on fp32as_pkg.
module fp32as_align (
	input  logic [31:0]              operand_a,
	input  logic [31:0]              operand_b,
	output fp32as_pkg::fp32as_align_t align
);
	logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
	logic [7:0] ea, eb, el;
	logic [23:0] ma, mb;
	logic [7:0] d;
	logic [5:0] sh;
	logic [63:0] bs, mask;

	always_comb begin
		nan_a = (operand_a[30:23] == 8'hFF) && (operand_a[22:0] != 23'd0);
		nan_b = (operand_b[30:23] == 8'hFF) && (operand_b[22:0] != 23'd0);
		inf_a = operand_a[30:0] == 31'h7F800000;
		inf_b = operand_b[30:0] == 31'h7F800000;
		zero_a = operand_a[30:0] == 31'd0;
		zero_b = operand_b[30:0] == 31'd0;
		align.special = 1'b1;
		if (nan_a || nan_b) begin
			align.special_word = fp32as_pkg::NanWord;
		end else if (inf_a) begin
			align.special_word = (inf_b && (operand_a[31] ^ operand_b[31])) ?
				fp32as_pkg::NanWord : operand_a;
		end else if (inf_b) begin
			align.special_word = operand_b;
		end else if (zero_a && zero_b) begin
			align.special_word = 32'd0;
		end else if (zero_a) begin
			align.special_word = operand_b;
		end else if (zero_b) begin
			align.special_word = operand_a;
		end else begin
			align.special_word = 32'd0;
			align.special = 1'b0;
		end
		ea = (operand_a[30:23] == 8'd0) ? 8'd1 : operand_a[30:23];
		eb = (operand_b[30:23] == 8'd0) ? 8'd1 : operand_b[30:23];
		ma = {operand_a[30:23] != 8'd0, operand_a[22:0]};
		mb = {operand_b[30:23] != 8'd0, operand_b[22:0]};
		swap = ea < eb;
		align.exp_big = swap ? eb : ea;
		el = swap ? ea : eb;
		align.sign_a = swap ? operand_b[31] : operand_a[31];
		align.sign_b = swap ? operand_a[31] : operand_b[31];
		align.sig_a = {8'd0, swap ? mb : ma, 32'd0};
		d = align.exp_big - el;
		align.exp_diff = d;
		sh = (d > 8'd63) ? 6'd63 : d[5:0];
		bs = {8'd0, swap ? ma : mb, 32'd0};
		mask = (64'd1 << sh) - 64'd1;
		align.sig_b = (bs >> sh) | {63'd0, (bs & mask) != 64'd0};
		align.aligned = d != 8'd0;
	end
endmodule

// ===== design/fp32as_norm.sv =====
// Stage 3 logic: leading-one search, normalize shift, range checks.
// Depends on fp32as_pkg.
module fp32as_norm (
	input  fp32as_pkg::fp32as_sum_t  sum,
	output fp32as_pkg::fp32as_norm_t norm
);
	logic [5:0] p;
	logic [63:0] sn;
	logic signed [10:0] e;
	logic signed [10:0] ds;
	logic [2:0] st;
	logic found;

	always_comb begin
		p = 6'd0;
		found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!found && sum.sum[i]) begin
				p = 6'(i);
				found = 1'b1;
			end
		end
		st = sum.aligned ? 3'd2 : 3'd1;
		e = $signed({3'd0, sum.exp_big}) + $signed({5'd0, p}) - 11'sd55;
		ds = $signed({3'd0, sum.exp_diff}) + $signed({5'd0, p}) - 11'sd55;
		if (p > 6'd55) begin
			sn = (sum.sum >> 1) | {63'd0, sum.sum[0]};
		end else begin
			sn = sum.sum << (6'd55 - p);
		end
		if (p != 6'd55) st = st + 3'd1;
		norm.sign = sum.sign;
		norm.exp_n = e[8:0];
		norm.sig = {1'b0, sn[55:32]} + {24'd0, sn[31]};
		// rounding counts a step when alignment plus normalize left dropped bits
		norm.round_step = ds > 11'sd0;
		norm.steps = st;
		norm.ovf = 1'b0;
		norm.unf = 1'b0;
		norm.done = 1'b1;
		if (sum.special) begin
			norm.word = sum.special_word;
			norm.steps = 3'd0;
		end else if (!found) begin
			norm.word = 32'd0;
			norm.steps = sum.aligned ? 3'd2 : 3'd1;
		end else if (e > 11'sd254) begin
			norm.word = {sum.sign, 31'h7F800000};
			norm.ovf = 1'b1;
		end else if (e < 11'sd1) begin
			norm.word = {sum.sign, 31'd0};
			norm.unf = 1'b1;
		end else begin
			norm.word = 32'd0;
			norm.done = 1'b0;
		end
	end
endmodule

// ===== design/fp32as_round.sv =====
// Stage 4 logic: rounding carry handling and result packing.
// Depends on fp32as_pkg.
module fp32as_round (
	input  fp32as_pkg::fp32as_norm_t norm,
	output fp32as_pkg::fp32as_res_t  res
);
	logic [8:0] e;
	logic [2:0] st;

	always_comb begin
		st = norm.steps + {2'd0, norm.round_step};
		e = norm.exp_n;
		res.ovf = norm.ovf;
		res.unf = norm.unf;
		if (norm.done) begin
			res.word = norm.word;
			st = norm.steps;
		end else if (norm.sig[24]) begin
			e = norm.exp_n + 9'd1;
			if (e > fp32as_pkg::ExpMax) begin
				res.word = {norm.sign, 31'h7F800000};
				res.ovf = 1'b1;
				st = st + 3'd1;
			end else begin
				res.word = {norm.sign, e[7:0], norm.sig[23:1]};
				st = st + 3'd2;
			end
		end else begin
			res.word = {norm.sign, e[7:0], norm.sig[22:0]};
		end
		res.steps = st;
	end
endmodule

// ===== design/fp32_adder_with_step_count_core.sv =====
// Pipelined IEEE-754 single adder with step count.
// Four register stages, the first loads on the accepting edge; the result is valid
// once the transaction reaches the last. Throughput one transaction per cycle while
// out_ready does not stall the pipe. Stages: align, add, normalize, round/pack.
// A stall holds every full stage behind it; a bubble stage is refilled while downstream waits.
// Reset (arst_n low) clears all stage valid bits; payload is not reset.
module fp32_adder_with_step_count_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sum_bits,
	output logic        overflow_flag,
	output logic        underflow_flag,
	output logic [2:0]  step_count
);
	fp32as_pkg::fp32as_align_t align_c, align_s1;
	fp32as_pkg::fp32as_sum_t   sum_c, sum_s2;
	fp32as_pkg::fp32as_norm_t  norm_c, norm_s3;
	fp32as_pkg::fp32as_res_t   res_c, res_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv4, adv3, adv2, adv1;

	// advance a stage when its output slot is empty or draining
	assign adv4 = !v_s4 || out_ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	fp32as_align u_align (.operand_a(operand_a), .operand_b(operand_b), .align(align_c));

	// add or subtract by magnitude
	always_comb begin
		sum_c.special = align_s1.special;
		sum_c.special_word = align_s1.special_word;
		sum_c.exp_big = align_s1.exp_big;
		sum_c.exp_diff = align_s1.exp_diff;
		sum_c.aligned = align_s1.aligned;
		if (align_s1.sign_a == align_s1.sign_b) begin
			sum_c.sum = align_s1.sig_a + align_s1.sig_b;
			sum_c.sign = align_s1.sign_a;
		end else if (align_s1.sig_a >= align_s1.sig_b) begin
			sum_c.sum = align_s1.sig_a - align_s1.sig_b;
			sum_c.sign = align_s1.sign_a;
		end else begin
			sum_c.sum = align_s1.sig_b - align_s1.sig_a;
			sum_c.sign = align_s1.sign_b;
		end
	end

	fp32as_norm  u_norm  (.sum(sum_s2), .norm(norm_c));
	fp32as_round u_round (.norm(norm_s3), .res(res_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) align_s1 <= align_c;
		if (adv2) sum_s2 <= sum_c;
		if (adv3) norm_s3 <= norm_c;
		if (adv4) res_s4 <= res_c;
	end

	assign out_valid = v_s4;
	assign sum_bits = res_s4.word;
	assign overflow_flag = res_s4.ovf;
	assign underflow_flag = res_s4.unf;
	assign step_count = res_s4.steps;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum_bits))
		else $error("result changed while stalled");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(overflow_flag && underflow_flag))
		else $error("both range flags set");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_count <= 3'd6)
		else $error("step count out of range");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction lost at stage 1");
endmodule

// ===== dv/tb_fp32_adder_with_step_count_core.sv =====
// Testbench for the pipelined fp32 adder with step count.
// Depends on design/fp32as_pkg.sv and design/fp32_adder_with_step_count_core.sv.
// A scoreboard class predicts each sum; a task drives the input handshake and an initial block the output one.
`timescale 1ns / 1ps

module tb_fp32_adder_with_step_count_core;

	typedef struct packed {
		logic [31:0] word;
		logic        ovf;
		logic        unf;
		logic [2:0]  steps;
	} sum_rec_t;

	// Predict one sum: special operands first, then align/add/normalize/round.
	function automatic sum_rec_t predict_sum(logic [31:0] a, logic [31:0] b);
		sum_rec_t r;
		logic sa, sb, sg, t1;
		logic [8:0] ea, eb, t9;
		logic [63:0] ma, mb, bigv, smlv, sumv, lost, t64;
		int d, e, s, p, st, sh;
		logic [24:0] kept;
		bit a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		r = '0;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
		a_inf = (a[30:0] == 31'h7F800000);
		b_inf = (b[30:0] == 31'h7F800000);
		a_zero = (a[30:0] == 0);
		b_zero = (b[30:0] == 0);
		if (a_nan || b_nan) begin
			r.word = fp32as_pkg::NanWord; return r;
		end
		if (a_inf) begin
			r.word = (b_inf && (a[31] != b[31])) ? fp32as_pkg::NanWord : a; return r;
		end
		if (b_inf) begin
			r.word = b; return r;
		end
		if (a_zero && b_zero) return r;
		if (a_zero) begin
			r.word = b; return r;
		end
		if (b_zero) begin
			r.word = a; return r;
		end
		sa = a[31]; sb = b[31];
		ea = {1'b0, a[30:23]}; eb = {1'b0, b[30:23]};
		ma = {41'd0, a[22:0]}; mb = {41'd0, b[22:0]};
		// subnormals take exponent 1 with no hidden bit
		if (ea == 0) ea = 1; else ma[23] = 1'b1;
		if (eb == 0) eb = 1; else mb[23] = 1'b1;
		if (ea < eb) begin
			t9 = ea; ea = eb; eb = t9;
			t1 = sa; sa = sb; sb = t1;
			t64 = ma; ma = mb; mb = t64;
		end
		d = ea - eb;
		st = (d > 0) ? 2 : 1;
		bigv = ma << 32;
		smlv = mb << 32;
		if (d > 0) begin
			sh = (d > 63) ? 63 : d;
			lost = smlv & ((64'd1 << sh) - 64'd1);
			smlv = smlv >> sh;
			if (lost != 0) smlv[0] = 1'b1;
		end
		if (sa == sb) begin
			sumv = bigv + smlv; sg = sa;
		end else if (bigv >= smlv) begin
			sumv = bigv - smlv; sg = sa;
		end else begin
			sumv = smlv - bigv; sg = sb;
		end
		if (sumv == 0) begin
			r.steps = st[2:0]; return r;
		end
		p = 63;
		while (!sumv[p]) p--;
		s = p - 55;
		e = ea + s;
		if (s > 0) sumv = (sumv >> 1) | {63'd0, sumv[0]};
		else if (s < 0) sumv = sumv << (-s);
		if (s != 0) st++;
		if (e > 254) begin
			r.word = {sg, 31'h7F800000}; r.ovf = 1; r.steps = st[2:0]; return r;
		end
		if (e < 1) begin
			r.word = {sg, 31'd0}; r.unf = 1; r.steps = st[2:0]; return r;
		end
		if (d + s > 0) st++;
		kept = {1'b0, sumv[55:32]} + {24'd0, sumv[31]};
		if (kept[24]) begin
			st++;
			kept = kept >> 1;
			e++;
			if (e > 254) begin
				r.word = {sg, 31'h7F800000}; r.ovf = 1; r.steps = st[2:0]; return r;
			end
			st++;
		end
		r.word = {sg, e[7:0], kept[22:0]};
		r.steps = st[2:0];
		return r;
	endfunction

	class sum_scoreboard;
		sum_rec_t pending[$];
		int mismatches;
		int checked;

		function void note_operands(logic [31:0] a, logic [31:0] b);
			pending.insert(pending.size(), predict_sum(a, b));
		endfunction

		function void check_sum(sum_rec_t got);
			sum_rec_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got.word);
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h ovf %b unf %b steps %0d, got %h ovf %b unf %b steps %0d",
						exp_r.word, exp_r.ovf, exp_r.unf, exp_r.steps,
						got.word, got.ovf, got.unf, got.steps);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [31:0] operand_a = 0;
	logic [31:0] operand_b = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] sum_bits;
	logic        overflow_flag;
	logic        underflow_flag;
	logic [2:0]  step_count;

	sum_scoreboard sb = new();
	bit calm;          // late phase: no idling on either side
	bit long_hold;     // receiver holds off for a long stretch
	longint cycles;

	localparam longint CycleLimit = 400000;

	fp32_adder_with_step_count_core dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Count cycles and end the run if it hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Sample accepted results at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_sum({sum_bits, overflow_flag, underflow_flag, step_count});
	end

	// Receiver: random stall bursts, one long hold-off, none in the calm phase.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 0;
				repeat (200) @(negedge clk);
				long_hold = 0;
			end
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 16);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	// Offer one transaction; hold it until accepted, then note the prediction.
	task automatic send_pair(logic [31:0] a, logic [31:0] b);
		int n;
		if (!calm && $urandom_range(0, 6) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 16);
			repeat (n) @(negedge clk);
		end
		in_valid <= 1;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_operands(a, b);
		@(negedge clk);
	endtask

	// Random single from a class: normal, subnormal, zero, inf, nan, or raw bits.
	function automatic logic [31:0] rand_float(logic [7:0] near);
		logic [31:0] w;
		int k;
		w = $urandom;
		k = $urandom_range(0, 19);
		case (k)
			0: w[30:23] = 0;
			1: w[30:0] = 0;
			2: w[30:0] = 31'h7F800000;
			3: w[30:23] = 8'hFF;
			4: w[30:23] = 8'hFE;
			5: w[30:23] = 8'($urandom_range(0, 2));
			6: w[22:0] = 23'h7FFFFF;
			7: ;
			default: w[30:23] = 8'(near + $urandom_range(0, 6) - 3);
		endcase
		return w;
	endfunction

	initial begin
		logic [31:0] a, b;
		logic [7:0] e;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: specials, extremes, cancellation, rounding carry, over/underflow.
		send_pair(32'h7FC00000, 32'h3F800000);
		send_pair(32'h3F800000, 32'hFF800001);
		send_pair(32'h7F800000, 32'hFF800000);
		send_pair(32'h7F800000, 32'h7F800000);
		send_pair(32'hFF800000, 32'h3F800000);
		send_pair(32'h3F800000, 32'h7F800000);
		send_pair(32'h80000000, 32'h00000000);
		send_pair(32'h80000000, 32'h00000001);
		send_pair(32'h40490FDB, 32'h00000000);
		send_pair(32'h00000001, 32'h00000001);
		send_pair(32'h807FFFFF, 32'h00000001);
		send_pair(32'h00800000, 32'h80000001);
		send_pair(32'h3F800000, 32'hBF800000);
		send_pair(32'h7F7FFFFF, 32'h7F7FFFFF);
		send_pair(32'hFF7FFFFF, 32'hF3800000);
		send_pair(32'h3FFFFFFF, 32'h33800000);
		send_pair(32'h3F800000, 32'h33800000);
		send_pair(32'h3F800000, 32'h00000001);
		send_pair(32'h3F800001, 32'hBF800000);
		send_pair(32'hFFFFFFFF, 32'h7FFFFFFF);
		send_pair(32'h4B7FFFFF, 32'h3F000000);
		send_pair(32'h3F800000, 32'h3F800000);
		send_pair(32'hBF7FFFFF, 32'h3F800000);

		// Random pairs; most with close exponents so alignment and rounding matter.
		for (int i = 0; i < 1300; i++) begin
			if (i == 300) long_hold = 1;
			if (i == 1100) calm = 1;
			e = 8'($urandom);
			a = rand_float(e);
			b = rand_float(e);
			send_pair(a, b);
		end
		in_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("checked %0d sums over specials, subnormals, cancellation, rounding carry,",
			sb.checked);
		$display("overflow and underflow, with random stalls and one long output hold-off");
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
